### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the colour morphology filter.
// Depends on nothing; the including module provides clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset.
`define CMM_ASSERT(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) expr) \
      else $error("cmm assertion failed");
// Checked at every clock edge, reset included.
`define CMM_ASSERT_ALWAYS(name, expr) \
   name: assert property (@(posedge clock) expr) \
      else $error("cmm assertion failed");
`else
`define CMM_ASSERT(name, expr)
`define CMM_ASSERT_ALWAYS(name, expr)
`endif
`endif

### rtl/cmm_pkg.sv
// Types, constants and helper functions of the colour morphology filter.
// Depends on nothing; used by every module of the block but cmm_ram.
package cmm_pkg;

   localparam int MAX_HALF  = 3;
   localparam int SPAN      = 2 * MAX_HALF + 1;
   localparam int LINES     = SPAN - 1;
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = 17;
   localparam int OROW_W    = 16;
   localparam int PIX_W     = 24;
   localparam int CELLS     = SPAN * SPAN;
   localparam int Q_DEPTH   = 4;
   localparam int QPTR_W    = $clog2(Q_DEPTH);
   localparam int QCNT_W    = QPTR_W + 1;
   localparam int OUT_DEPTH = 8;
   localparam int OPTR_W    = $clog2(OUT_DEPTH);
   localparam int OCNT_W    = OPTR_W + 1;

   typedef enum logic [2:0] {
      REG_SHAPE   = 3'd0,
      REG_HALF    = 3'd1,
      REG_USE_MAX = 3'd2,
      REG_WIDTH   = 3'd3,
      REG_HEIGHT  = 3'd4
   } csr_reg_type;

   localparam logic [3:0] SHAPE_SQUARE  = 4'd0;
   localparam logic [3:0] SHAPE_DIAMOND = 4'd1;
   localparam logic [3:0] SHAPE_DISK    = 4'd2;
   localparam logic [3:0] SHAPE_VERT    = 4'd3;
   localparam logic [3:0] SHAPE_ANTI    = 4'd4;
   localparam logic [3:0] SHAPE_HORIZ   = 4'd5;
   localparam logic [3:0] SHAPE_DIAG    = 4'd6;
   localparam logic [3:0] SHAPE_CROSS   = 4'd7;
   localparam logic [3:0] SHAPE_PLUS    = 4'd8;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_end;
   } rsp_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic [PIX_W-1:0]  pix;
      logic [COL_W-1:0]  col;
      logic [OROW_W-1:0] orow;
      logic [COL_W-1:0]  ocol;
      logic              emit;
      logic              frame_end;
   } item_type;

   typedef struct packed {
      logic [10:0]      w_eff;
      logic [15:0]      h_eff;
      logic [1:0]       hs;
      logic             use_max;
      logic [CELLS-1:0] cell_mask;
   } cfg_type;

   typedef struct packed {
      logic [QCNT_W-1:0] q_count;
   } front_stat_type;

   typedef struct packed {
      logic [OCNT_W-1:0] fifo_count;
      logic [1:0]        inflight;
   } back_stat_type;

   // Element bits indexed by window cell: row j counts up from the newest
   // line, column k counts back from the newest pixel.
   function automatic logic [CELLS-1:0] build_cell_mask(input logic [3:0] kind,
                                                        input logic [1:0] hs);
      int dr, dc, ar, ac, h;
      logic on;
      logic [CELLS-1:0] m;
      h = int'(hs);
      m = '0;
      for (int j = 0; j < SPAN; j++) begin
         for (int k = 0; k < SPAN; k++) begin
            dr = h - j;
            dc = h - k;
            ar = (dr < 0) ? -dr : dr;
            ac = (dc < 0) ? -dc : dc;
            unique case (kind)
               SHAPE_SQUARE:  on = 1'b1;
               SHAPE_DIAMOND: on = (ar + ac) <= h;
               SHAPE_DISK:    on = (dr * dr + dc * dc) <= h * h;
               SHAPE_VERT:    on = dc == 0;
               SHAPE_ANTI:    on = dr == -dc;
               SHAPE_HORIZ:   on = dr == 0;
               SHAPE_DIAG:    on = dr == dc;
               SHAPE_CROSS:   on = (dr == dc) || (dr == -dc);
               SHAPE_PLUS:    on = (dr == 0) || (dc == 0);
               default:       on = (dr == 0) && (dc == 0);
            endcase
            if (j > 2 * h || k > 2 * h) begin
               on = 1'b0;
            end
            m[j * SPAN + k] = on;
         end
      end
      return m;
   endfunction

   function automatic logic [7:0] pick(input logic [7:0] a, input logic [7:0] b,
                                       input logic use_max);
      if (use_max) begin
         return (b > a) ? b : a;
      end
      return (b < a) ? b : a;
   endfunction

endpackage

### rtl/cmm_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module cmm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

### rtl/cmm_front.sv
// Front end: frame position counters, item classification and the short
// queue towards the back end. Depends on cmm_pkg.
module cmm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  cmm_pkg::cfg_type        cfg,
   input  logic                    push,
   output logic                    full,
   input  cmm_pkg::req_type        req_data,
   input  logic                    q_pop,
   output logic                    q_valid,
   output cmm_pkg::item_type       q_item,
   output cmm_pkg::front_stat_type stat
);
   import cmm_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  ocol_ff, ocol_in;
   logic [OROW_W-1:0] orow_ff, orow_in;
   item_type          q_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic [COL_W-1:0]  wm1;
   logic [OROW_W-1:0] hm1;
   logic              accept, in_frame, reached, past, frame_last, q_push;
   item_type          item;
   logic [10:0]       wm1_wide;
   logic [27:0]       n_pos, lag_pos;

   assign full     = count_ff == QCNT_W'(Q_DEPTH);
   assign accept   = push && !full;
   assign wm1_wide = cfg.w_eff - 11'd1;
   assign wm1      = wm1_wide[COL_W-1:0];
   assign hm1      = cfg.h_eff - 16'd1;
   assign in_frame = row_ff < {1'b0, cfg.h_eff};
   // Linear frame position against the lag; the half size may exceed the
   // width, so the lag is formed in full rather than as a row and column.
   assign n_pos    = ({11'd0, row_ff} * {17'd0, cfg.w_eff}) + {18'd0, col_ff};
   assign lag_pos  = ({26'd0, cfg.hs} * {17'd0, cfg.w_eff}) + {26'd0, cfg.hs};
   assign reached  = n_pos >= lag_pos;
   assign past       = reached && (orow_ff >= cfg.h_eff);
   assign frame_last = (orow_ff == hm1) && (ocol_ff == wm1);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      q_push  = 1'b0;
      item.pix       = {req_data.in_red, req_data.in_green, req_data.in_blue};
      item.col       = col_ff;
      item.orow      = orow_ff;
      item.ocol      = ocol_ff;
      item.emit      = reached;
      item.frame_end = reached && frame_last;
      if (accept) begin
         priority if (in_frame && req_data.flush) begin
            // Early flush: dropped without effect.
         end else if (past) begin
            col_in  = '0;
            row_in  = '0;
            ocol_in = '0;
            orow_in = '0;
         end else begin
            q_push = 1'b1;
            if (col_ff == wm1) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
            if (reached) begin
               if (ocol_ff == wm1) begin
                  ocol_in = '0;
                  orow_in = orow_ff + OROW_W'(1);
               end else begin
                  ocol_in = ocol_ff + COL_W'(1);
               end
               if (frame_last) begin
                  col_in  = '0;
                  row_in  = '0;
                  ocol_in = '0;
                  orow_in = '0;
               end
            end
         end
      end
      wr_ptr_in = q_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(q_push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign q_valid      = count_ff != '0;
   assign q_item       = q_ff[rd_ptr_ff];
   assign stat.q_count = count_ff;
endmodule

### rtl/cmm_back.sv
// Back end: line memories, 7x7 window, two-stage min/max reduction and the
// result queue. Depends on cmm_pkg and cmm_ram.
module cmm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  cmm_pkg::cfg_type       cfg,
   input  logic                   q_valid,
   input  cmm_pkg::item_type      q_item,
   output logic                   q_pop,
   output logic                   empty,
   input  logic                   pop,
   output cmm_pkg::rsp_type       rsp_data,
   output cmm_pkg::back_stat_type stat
);
   import cmm_pkg::*;

   logic [PIX_W-1:0]  ram_q [LINES];
   logic [PIX_W-1:0]  col_vec [SPAN];
   logic [PIX_W-1:0]  byp_data_ff [LINES];
   logic              byp_ff;
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   item_type          s1_ff;
   logic              s2_emit_ff, s2_fe_ff, s3_emit_ff, s3_fe_ff;
   logic [SPAN-1:0]   rowv_in, rowv_ff, colv_in, colv_ff;
   logic [PIX_W-1:0]  win_ff [SPAN][SPAN];
   logic [PIX_W-1:0]  rowred_in [SPAN];
   logic [PIX_W-1:0]  rowred_ff [SPAN];
   logic [PIX_W-1:0]  final_pix;
   rsp_type           fifo_ff [OUT_DEPTH];
   logic [OPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OCNT_W-1:0] fcount_ff;
   logic [1:0]        inflight;
   logic              fifo_push, fifo_pop;
   logic [4:0]        credit;

   assign inflight = 2'(s1_valid_ff) + 2'(s2_valid_ff) + 2'(s3_valid_ff);
   assign credit   = {1'b0, fcount_ff} + 5'(inflight);
   assign q_pop    = q_valid && (credit < 5'(OUT_DEPTH));

   for (genvar g = 0; g < LINES; g++) begin : g_line
      cmm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
         .clock   (clock),
         .wr_en   (s1_valid_ff),
         .wr_addr (s1_ff.col),
         .wr_data (col_vec[g]),
         .rd_addr (q_item.col),
         .rd_data (ram_q[g])
      );
   end

   always_comb begin
      col_vec[0] = s1_ff.pix;
      for (int j = 1; j < SPAN; j++) begin
         col_vec[j] = byp_ff ? byp_data_ff[j-1] : ram_q[j-1];
      end
   end

   // Window border clipping for the centre carried by the item in stage one.
   always_comb begin
      logic [17:0] tr;
      logic [11:0] tc;
      for (int j = 0; j < SPAN; j++) begin
         tr = {2'b00, s1_ff.orow} + 18'(cfg.hs) - 18'(j);
         rowv_in[j] = !tr[17] && (tr < {2'b00, cfg.h_eff});
         tc = {2'b00, s1_ff.ocol} + 12'(cfg.hs) - 12'(j);
         colv_in[j] = !tc[11] && (tc < {1'b0, cfg.w_eff});
      end
   end

   always_comb begin
      logic [7:0] r, g, b, ident;
      ident = cfg.use_max ? 8'd0 : 8'd255;
      for (int j = 0; j < SPAN; j++) begin
         r = ident;
         g = ident;
         b = ident;
         for (int k = 0; k < SPAN; k++) begin
            if (cfg.cell_mask[j * SPAN + k] && rowv_ff[j] && colv_ff[k]) begin
               r = pick(r, win_ff[j][k][23:16], cfg.use_max);
               g = pick(g, win_ff[j][k][15:8], cfg.use_max);
               b = pick(b, win_ff[j][k][7:0], cfg.use_max);
            end
         end
         rowred_in[j] = {r, g, b};
      end
   end

   always_comb begin
      logic [7:0] r, g, b;
      r = rowred_ff[0][23:16];
      g = rowred_ff[0][15:8];
      b = rowred_ff[0][7:0];
      for (int j = 1; j < SPAN; j++) begin
         r = pick(r, rowred_ff[j][23:16], cfg.use_max);
         g = pick(g, rowred_ff[j][15:8], cfg.use_max);
         b = pick(b, rowred_ff[j][7:0], cfg.use_max);
      end
      final_pix = {r, g, b};
   end

   assign fifo_push = s3_valid_ff && s3_emit_ff;
   assign fifo_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fcount_ff   <= '0;
      end else begin
         s1_valid_ff <= q_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         // Same line address read and written in the same cycle: forward.
         byp_ff      <= q_pop && s1_valid_ff && (q_item.col == s1_ff.col);
         if (fifo_push) begin
            wr_ptr_ff <= wr_ptr_ff + OPTR_W'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + OPTR_W'(1);
         end
         fcount_ff <= fcount_ff + OCNT_W'(fifo_push) - OCNT_W'(fifo_pop);
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= q_item;
      for (int j = 0; j < LINES; j++) begin
         byp_data_ff[j] <= col_vec[j];
      end
      if (s1_valid_ff) begin
         for (int j = 0; j < SPAN; j++) begin
            win_ff[j][0] <= col_vec[j];
            for (int k = 1; k < SPAN; k++) begin
               win_ff[j][k] <= win_ff[j][k-1];
            end
         end
      end
      rowv_ff    <= rowv_in;
      colv_ff    <= colv_in;
      s2_emit_ff <= s1_ff.emit;
      s2_fe_ff   <= s1_ff.frame_end;
      rowred_ff  <= rowred_in;
      s3_emit_ff <= s2_emit_ff;
      s3_fe_ff   <= s2_fe_ff;
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff] <= '{out_red:   final_pix[23:16],
                                 out_green: final_pix[15:8],
                                 out_blue:  final_pix[7:0],
                                 frame_end: s3_fe_ff};
      end
   end

   assign empty           = fcount_ff == '0;
   assign rsp_data        = fifo_ff[rd_ptr_ff];
   assign stat.fifo_count = fcount_ff;
   assign stat.inflight   = inflight;
endmodule

### rtl/color_morphology_min_max_filter.sv
// Top level of the colour morphology (erosion / dilation) filter.
// Depends on cmm_pkg, cmm_front, cmm_back, cmm_ram and assert_macros.svh.
//
// The block takes RGB pixels in raster order, one transfer per clock while
// full is low, and returns for each pixel the per-channel minimum (erosion)
// or maximum (dilation) over the chosen structuring element, clipped at the
// image borders. Results lag the input by half_size rows plus half_size
// pixels; after the last pixel of a frame, flush transfers drain the
// remaining results, and the last result of the frame carries frame_end. A
// flush sent before the frame is complete is dropped, and a pixel sent after
// it acts as a flush. Sustained throughput is one item per clock on both
// sides while results are popped as they arrive. An item passes from its
// input transfer through the front queue, at whose end the line memories
// are read into stage one, then into the window and through the row
// reduction register of the min/max tree into the result queue, where its
// result is offered. The result queue holds eight results, and the back end
// takes an item only when that queue has room for everything in flight, so
// its pipeline never stalls. Six line memories of 1024 by 24 bits hold the
// previous rows. Configuration registers are written through the csr channel,
// which is always ready, and must only be changed while the block is idle.
`include "assert_macros.svh"

module color_morphology_min_max_filter (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  cmm_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output cmm_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import cmm_pkg::*;

   logic [3:0]       shape_ff, shape_in;
   logic [1:0]       half_ff, half_in;
   logic             use_max_ff, use_max_in;
   logic [10:0]      width_ff, width_in;
   logic [15:0]      height_ff, height_in;
   logic [CELLS-1:0] mask_ff, mask_in;
   logic             csr_write;
   cfg_type          cfg;
   logic             q_valid, q_pop;
   item_type         q_item;
   front_stat_type   front_stat;
   back_stat_type    back_stat;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register file; the element mask is rebuilt whenever shape or size change.
   always_comb begin
      shape_in   = shape_ff;
      half_in    = half_ff;
      use_max_in = use_max_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_SHAPE:   shape_in   = csr_wdata[3:0];
            REG_HALF:    half_in    = csr_wdata[1:0];
            REG_USE_MAX: use_max_in = csr_wdata[0];
            REG_WIDTH:   width_in   = csr_wdata[10:0];
            REG_HEIGHT:  height_in  = csr_wdata;
            default: begin
            end
         endcase
      end
      mask_in = build_cell_mask(shape_in, half_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff   <= SHAPE_SQUARE;
         half_ff    <= 2'd1;
         use_max_ff <= 1'b0;
         width_ff   <= 11'd640;
         height_ff  <= 16'd480;
         mask_ff    <= build_cell_mask(SHAPE_SQUARE, 2'd1);
      end else begin
         shape_ff   <= shape_in;
         half_ff    <= half_in;
         use_max_ff <= use_max_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         mask_ff    <= mask_in;
      end
   end

   // A zero width or height counts as one, and the width saturates at the
   // line memory depth.
   always_comb begin
      if (width_ff == '0) begin
         cfg.w_eff = 11'd1;
      end else if (width_ff > 11'(MAX_WIDTH)) begin
         cfg.w_eff = 11'(MAX_WIDTH);
      end else begin
         cfg.w_eff = width_ff;
      end
      cfg.h_eff     = (height_ff == '0) ? 16'd1 : height_ff;
      cfg.hs        = half_ff;
      cfg.use_max   = use_max_ff;
      cfg.cell_mask = mask_ff;
   end

   cmm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_pop    (q_pop),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .stat     (front_stat)
   );

   cmm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .stat     (back_stat)
   );

   // The result queue always has room for every item inside the back end.
   `CMM_ASSERT(a_credit, ({1'b0, back_stat.fifo_count} + 5'(back_stat.inflight)) <= 5'(OUT_DEPTH))
   // The front queue never holds more entries than it has.
   `CMM_ASSERT(a_queue_bound, front_stat.q_count <= QCNT_W'(Q_DEPTH))
   // Reset leaves both sides with nothing pending.
   `CMM_ASSERT_ALWAYS(a_reset_clear, reset |=> (empty && !full))
endmodule
